// ===== rtl/sle_pkg.sv =====
// Package for the sequential list engine: operation codes, status codes and
// size constants used by the core. No dependencies.
`default_nettype none
package sle_pkg;
  localparam int unsigned DEPTH_DEF = 64;

  localparam logic [3:0] OP_PUSHBACK  = 4'd0;
  localparam logic [3:0] OP_POPBACK   = 4'd1;
  localparam logic [3:0] OP_PUSHFRONT = 4'd2;
  localparam logic [3:0] OP_POPFRONT  = 4'd3;
  localparam logic [3:0] OP_INSERT    = 4'd4;
  localparam logic [3:0] OP_ERASE     = 4'd5;
  localparam logic [3:0] OP_FIND      = 4'd6;
  localparam logic [3:0] OP_REMOVE    = 4'd7;
  localparam logic [3:0] OP_REMOVEALL = 4'd8;
  localparam logic [3:0] OP_SORT      = 4'd9;
  localparam logic [3:0] OP_SEARCH    = 4'd10;
  localparam logic [3:0] OP_SIZE      = 4'd11;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_BADPOS   = 3'd4;
endpackage
`default_nettype wire

// ===== rtl/sle_if.sv =====
// Request and result channel interfaces of the sequential list engine.
// Depends on nothing; widths follow DEPTH given at instantiation.
`default_nettype none
interface sle_req_if #(parameter int unsigned DEPTH = 64);
  localparam int unsigned PW = $clog2(DEPTH + 1);
  localparam int unsigned UW = $clog2(DEPTH);
  logic                 valid;
  logic                 ready;
  logic [3:0]           mode;
  logic signed [31:0]   value;
  logic [PW-1:0]        position;
  logic [UW-1:0]        upper_bound;
  modport source (output valid, mode, value, position, upper_bound, input ready);
  modport sink   (input valid, mode, value, position, upper_bound, output ready);
endinterface

interface sle_rsp_if #(parameter int unsigned DEPTH = 64);
  localparam int unsigned PW = $clog2(DEPTH + 1);
  localparam int unsigned UW = $clog2(DEPTH);
  logic          valid;
  logic          ready;
  logic [2:0]    status;
  logic [UW-1:0] found_index;
  logic [PW-1:0] element_total;
  modport source (output valid, status, found_index, element_total, input ready);
  modport sink   (input valid, status, found_index, element_total, output ready);
endinterface
`default_nettype wire

// ===== rtl/sequential_list_engine_core.sv =====
// Sequential list engine: packed list of signed words in one synchronous RAM
// plus an entry count. Depends on sle_pkg and the interfaces in sle_if.sv.
//
// Usage: in_ carries one request (mode, value, position, upper_bound); out_
// returns one result (status, found_index, element_total) per request.
// One request is worked on at a time; in_ready is high only in the idle state.
// Work per request, n = entries in use:
//   size, push/pop back, unused modes, rejected requests: no RAM walk
//   push front, insert, pop front, erase, find, remove, remove all: walk the list
//     (one RAM read per shifted or scanned entry, a write per entry shifted or kept)
//   search: binary search, at most log2(DEPTH) + 1 probes
//   sort: bubble passes, up to n*(n-1)/2 compare steps, two writes on a swap
// Reset clears the count and the control state; the RAM is not cleared.
// The result sits in an output register until out_ready; the next request
// is taken once the result has been handed over.
`default_nettype none
module sequential_list_engine_core #(
  parameter int unsigned DEPTH = sle_pkg::DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  sle_req_if.sink   in_req,
  sle_rsp_if.source out_rsp
);
  import sle_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_WAIT, S_RSP, S_SORT_RD0, S_SORT_RD1, S_SORT_CMP,
    S_SORT_WR, S_SRCH_WAIT
  } state_t;

  typedef enum logic [2:0] {
    W_OPEN, W_CLOSE, W_SCAN, W_COMPACT, W_SRCH
  } walk_t;

  state_t          state_r;
  walk_t           walk_r;
  logic [3:0]      mode_r;
  logic [31:0]     val_r;
  logic [PW-1:0]   cnt_r;
  logic [PW-1:0]   i_r;      // walk index
  logic [PW-1:0]   k_r;      // write index / stop bound
  logic [PW-1:0]   lo_r, hi_r;
  logic [PW-1:0]   pass_r;
  logic            swapped_r;
  logic [31:0]     a_r;
  logic [2:0]      st_r;
  logic [AW-1:0]   idx_r;
  logic            ovalid_r;

  logic [31:0]     mem [DEPTH];
  logic [31:0]     rdata_r;
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [31:0]     wdata;
  logic            re;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  function automatic logic lt_s(input logic [31:0] a, input logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  logic [PW-1:0] mid;
  assign mid = PW'((({1'b0, lo_r} + {1'b0, hi_r}) >> 1));

  always_comb begin
    we = 1'b0; waddr = '0; wdata = val_r; re = 1'b0; raddr = '0;
    case (state_r)
      S_RD: begin
        re = 1'b1;
        case (walk_r)
          W_OPEN:  raddr = AW'(i_r - 1'b1);
          W_SRCH:  raddr = AW'(mid);
          default: raddr = AW'(i_r);
        endcase
      end
      S_WAIT: begin
        case (walk_r)
          W_OPEN:  begin we = 1'b1; waddr = AW'(i_r); wdata = rdata_r; end
          W_CLOSE: begin we = 1'b1; waddr = AW'(i_r - 1'b1); wdata = rdata_r; end
          W_COMPACT: begin
            we = (rdata_r != val_r); waddr = AW'(k_r); wdata = rdata_r;
          end
          default: ;
        endcase
      end
      S_RSP: begin
        we = (walk_r == W_OPEN) && (st_r == ST_OK) && (mode_r != OP_SIZE);
        waddr = AW'(k_r); wdata = val_r;
      end
      S_SORT_RD0: begin re = 1'b1; raddr = AW'(i_r); end
      S_SORT_RD1: begin re = 1'b1; raddr = AW'(i_r + 1'b1); end
      S_SORT_WR:  begin we = 1'b1; waddr = AW'(i_r + 1'b1); wdata = a_r; end
      S_SORT_CMP: begin
        we = lt_s(rdata_r, a_r); waddr = AW'(i_r); wdata = rdata_r;
      end
      default: ;
    endcase
  end

  assign in_req.ready          = (state_r == S_IDLE);
  assign out_rsp.valid         = ovalid_r;
  assign out_rsp.status        = st_r;
  assign out_rsp.found_index   = idx_r;
  assign out_rsp.element_total = cnt_r;

  logic [PW-1:0] pos_in;
  assign pos_in = in_req.position;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0; ovalid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (in_req.valid) begin
          mode_r <= in_req.mode; val_r <= in_req.value;
          st_r <= ST_OK; idx_r <= '0; walk_r <= W_SCAN;
          state_r <= S_RSP;
          case (in_req.mode)
            OP_PUSHBACK, OP_PUSHFRONT, OP_INSERT: begin
              logic [PW-1:0] p;
              p = (in_req.mode == OP_PUSHBACK) ? cnt_r :
                  (in_req.mode == OP_PUSHFRONT) ? '0 : pos_in;
              if (p > cnt_r) st_r <= ST_BADPOS;
              else if (cnt_r >= DEPTH_P) st_r <= ST_FULL;
              else begin
                walk_r <= W_OPEN; i_r <= cnt_r; k_r <= p;
                state_r <= (cnt_r > p) ? S_RD : S_RSP;
              end
            end
            OP_POPBACK, OP_POPFRONT, OP_ERASE: begin
              logic [PW-1:0] p;
              p = (in_req.mode == OP_POPBACK) ? cnt_r - 1'b1 :
                  (in_req.mode == OP_POPFRONT) ? '0 : pos_in;
              if (cnt_r == '0) st_r <= ST_EMPTY;
              else if (p >= cnt_r) st_r <= ST_BADPOS;
              else begin
                walk_r <= W_CLOSE; i_r <= p + 1'b1;
                state_r <= (p + 1'b1 < cnt_r) ? S_RD : S_RSP;
                if (!(p + 1'b1 < cnt_r)) cnt_r <= cnt_r - 1'b1;
              end
            end
            OP_FIND, OP_REMOVE: begin
              if (cnt_r == '0) st_r <= ST_EMPTY;
              else begin walk_r <= W_SCAN; i_r <= '0; state_r <= S_RD; end
            end
            OP_REMOVEALL: begin
              if (cnt_r == '0) st_r <= ST_EMPTY;
              else begin
                walk_r <= W_COMPACT; i_r <= '0; k_r <= '0; state_r <= S_RD;
              end
            end
            OP_SORT: begin
              if (cnt_r >= PW'(2)) begin
                pass_r <= '0; i_r <= '0; swapped_r <= 1'b0;
                state_r <= S_SORT_RD0;
              end
            end
            OP_SEARCH: begin
              if (pos_in > PW'(in_req.upper_bound)) st_r <= ST_NOTFOUND;
              else if (PW'(in_req.upper_bound) >= cnt_r) st_r <= ST_BADPOS;
              else begin
                walk_r <= W_SRCH; lo_r <= pos_in;
                hi_r <= PW'(in_req.upper_bound);
                st_r <= ST_NOTFOUND; state_r <= S_RD;
              end
            end
            default: ;
          endcase
        end
        S_RD: state_r <= S_WAIT;
        S_WAIT: begin
          state_r <= S_RD;
          case (walk_r)
            W_OPEN: begin
              i_r <= i_r - 1'b1;
              if (i_r - 1'b1 <= k_r) state_r <= S_RSP;
            end
            W_CLOSE: begin
              i_r <= i_r + 1'b1;
              if (i_r + 1'b1 >= cnt_r) begin
                state_r <= S_RSP; cnt_r <= cnt_r - 1'b1;
              end
            end
            W_SCAN: begin
              if (rdata_r == val_r) begin
                if (mode_r == OP_FIND) begin
                  idx_r <= AW'(i_r); state_r <= S_RSP;
                end else begin
                  walk_r <= W_CLOSE; i_r <= i_r + 1'b1;
                  if (i_r + 1'b1 >= cnt_r) begin
                    state_r <= S_RSP; cnt_r <= cnt_r - 1'b1;
                  end
                end
              end else begin
                i_r <= i_r + 1'b1;
                if (i_r + 1'b1 >= cnt_r) begin
                  st_r <= ST_NOTFOUND; state_r <= S_RSP;
                end
              end
            end
            W_COMPACT: begin
              logic [PW-1:0] kn;
              kn = k_r + PW'(rdata_r != val_r);
              k_r <= kn; i_r <= i_r + 1'b1;
              if (i_r + 1'b1 >= cnt_r) begin
                cnt_r <= kn; state_r <= S_RSP;
              end
            end
            default: begin
              if (rdata_r == val_r) begin
                st_r <= ST_OK; idx_r <= AW'(mid); state_r <= S_RSP;
              end else if (lt_s(val_r, rdata_r)) begin
                if (mid == '0 || mid - 1'b1 < lo_r) state_r <= S_RSP;
                else hi_r <= mid - 1'b1;
              end else begin
                if (mid + 1'b1 > hi_r) state_r <= S_RSP;
                else lo_r <= mid + 1'b1;
              end
            end
          endcase
        end
        S_SORT_RD0: state_r <= S_SORT_RD1;
        S_SORT_RD1: begin a_r <= rdata_r; state_r <= S_SORT_CMP; end
        S_SORT_CMP: begin
          if (lt_s(rdata_r, a_r)) begin
            swapped_r <= 1'b1; state_r <= S_SORT_WR;
          end else begin
            if (i_r + PW'(2) < cnt_r - pass_r) begin
              i_r <= i_r + 1'b1; state_r <= S_SORT_RD0;
            end else if (!swapped_r || pass_r + PW'(2) >= cnt_r) begin
              state_r <= S_RSP;
            end else begin
              pass_r <= pass_r + 1'b1; i_r <= '0; swapped_r <= 1'b0;
              state_r <= S_SORT_RD0;
            end
          end
        end
        S_SORT_WR: begin
          if (i_r + PW'(2) < cnt_r - pass_r) begin
            i_r <= i_r + 1'b1; state_r <= S_SORT_RD0;
          end else if (pass_r + PW'(2) >= cnt_r) begin
            state_r <= S_RSP;
          end else begin
            pass_r <= pass_r + 1'b1; i_r <= '0; swapped_r <= 1'b0;
            state_r <= S_SORT_RD0;
          end
        end
        S_RSP: begin
          if (!ovalid_r) begin
            ovalid_r <= 1'b1;
            if (walk_r == W_OPEN && st_r == ST_OK) cnt_r <= cnt_r + 1'b1;
            walk_r <= W_SCAN;
          end else if (out_rsp.ready) begin
            ovalid_r <= 1'b0; state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_P) else $error("count above depth");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> state_r == S_RSP) else $error("result outside response state");
  a_cnt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && $past(state_r) == S_IDLE) |-> $stable(cnt_r))
    else $error("count changed while idle");
  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && st_r != ST_OK) |-> idx_r == '0) else $error("index on failure");
endmodule
`default_nettype wire
